>>> rtl/drm_pkg.sv
// ----------------------------------------------------------------------------
// drm_pkg
// Shared types and constants of the dual motor ramp controller.
// ----------------------------------------------------------------------------
package drm_pkg;

	localparam int unsigned PWM_RANGE_DEF = 1000000;
	localparam int unsigned DUTY_W        = 7;
	localparam int unsigned PWM_W         = 20;
	localparam int unsigned MAG_W         = 14;
	localparam logic [6:0]  RAMP_STEP_RST = 7'd5;
	localparam logic [6:0]  DUTY_MAX      = 7'd100;

	typedef enum logic [2:0] {
		REQ_TICK,
		REQ_SET,
		REQ_STOP,
		REQ_STOP_ALL,
		REQ_FORWARD,
		REQ_BACKWARD,
		REQ_TURN_LEFT,
		REQ_TURN_RIGHT
	} req_e;

	typedef enum logic [1:0] {
		STATUS_OK,
		STATUS_INVALID,
		STATUS_NOT_ENABLED
	} status_e;

	typedef enum logic {
		CFG_ENABLED,
		CFG_RAMP_STEP
	} cfg_idx_e;

	typedef struct packed {
		req_e              req;
		logic              msel;
		logic [7:0]        speed;
		logic              dir;
		logic [7:0]        radius;
		logic [MAG_W-1:0]  mag;
		logic              neg;
	} drm_s1_t;

	typedef struct packed {
		logic              tick;
		logic              set;
		logic              stop;
		logic [DUTY_W-1:0] duty;
		logic              dir;
	} drm_motor_cmd_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty;
		logic              dir;
		logic              settled;
	} drm_motor_view_t;

endpackage

>>> rtl/drm_if.sv
// ----------------------------------------------------------------------------
// drm_cmd_if / drm_rsp_if
// Valid/ready channels for commands and results of the motor controller.
// ----------------------------------------------------------------------------
interface drm_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] req_type;
	logic       motor_select;
	logic [7:0] speed_value;
	logic       direction;
	logic [7:0] radius_value;

	modport source (output valid, req_type, motor_select, speed_value, direction,
		radius_value, input ready);
	modport sink (input valid, req_type, motor_select, speed_value, direction,
		radius_value, output ready);
endinterface

interface drm_rsp_if;
	logic        valid;
	logic        ready;
	logic        left_in1_gpio;
	logic        left_in2_gpio;
	logic [19:0] left_pwm_word;
	logic        right_in1_gpio;
	logic        right_in2_gpio;
	logic [19:0] right_pwm_word;
	logic [6:0]  left_duty;
	logic [6:0]  right_duty;
	logic [1:0]  status;
	logic        ramping;

	modport source (output valid, left_in1_gpio, left_in2_gpio, left_pwm_word,
		right_in1_gpio, right_in2_gpio, right_pwm_word, left_duty, right_duty,
		status, ramping, input ready);
	modport sink (input valid, left_in1_gpio, left_in2_gpio, left_pwm_word,
		right_in1_gpio, right_in2_gpio, right_pwm_word, left_duty, right_duty,
		status, ramping, output ready);
endinterface

>>> rtl/dual_motor_ramp_controller.sv
// ----------------------------------------------------------------------------
// dual_motor_ramp_controller
// Two H-bridge channels with tick-driven soft-start ramps and PWM words.
// ----------------------------------------------------------------------------
// Accepts one command or tick per clock while the result channel is not stalled
// and returns one result per item. The input register holds the command and the
// turn product; the second stage scales it by a reciprocal multiply, updates both
// motor states and loads the result register. Throughput is set by the result
// register alone; a stalled result holds one item in the input register behind it.
module dual_motor_ramp_controller #(
	parameter int unsigned PWM_RANGE = drm_pkg::PWM_RANGE_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_index,
	input  logic [6:0] cfg_data,
	drm_cmd_if.sink    cmd,
	drm_rsp_if.source  rsp
);

	localparam logic [12:0] RECIP  = 13'd5243;
	localparam int unsigned RSHIFT = 19;

	logic                     enabled_q;
	logic [6:0]               ramp_q;
	logic [6:0]               step;
	logic                     advance;
	logic                     fire;
	logic                     valid_s1;
	drm_pkg::drm_s1_t         item_s1;
	logic [26:0]              scaled;
	logic [6:0]               inner_duty;
	drm_pkg::status_e         status;
	drm_pkg::drm_motor_cmd_t  mcmd [2];
	drm_pkg::drm_motor_view_t view [2];
	logic [19:0]              pwm_lut [128];
	logic                     inner;
	logic                     bad_speed;

	for (genvar i = 0; i < 128; i++) begin : g_lut
		localparam longint Val = (i <= 100) ?
			(longint'(100 - i) * longint'(PWM_RANGE)) / 100 : 0;
		assign pwm_lut[i] = 20'(Val);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
			ramp_q    <= drm_pkg::RAMP_STEP_RST;
		end else if (cfg_wr_en) begin
			case (drm_pkg::cfg_idx_e'(cfg_index))
				drm_pkg::CFG_ENABLED:   enabled_q <= cfg_data[0];
				drm_pkg::CFG_RAMP_STEP: ramp_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign step = (ramp_q == 7'd0) ? 7'd1 :
		((ramp_q > drm_pkg::DUTY_MAX) ? drm_pkg::DUTY_MAX : ramp_q);

	assign advance = !rsp.valid || rsp.ready;
	assign fire    = valid_s1 && advance;

	drm_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	assign scaled     = 27'(item_s1.mag) * 27'(RECIP);
	assign inner_duty = scaled[RSHIFT+6:RSHIFT];
	assign inner      = (item_s1.req == drm_pkg::REQ_TURN_LEFT) ? 1'b0 : 1'b1;
	assign bad_speed  = item_s1.speed > 8'd100;

	always_comb begin
		mcmd[0] = '0;
		mcmd[1] = '0;
		status  = drm_pkg::STATUS_OK;
		if (item_s1.req == drm_pkg::REQ_TICK) begin
			mcmd[0].tick = 1'b1;
			mcmd[1].tick = 1'b1;
		end else if (!enabled_q) begin
			status = drm_pkg::STATUS_NOT_ENABLED;
		end else begin
			case (item_s1.req)
				drm_pkg::REQ_SET: begin
					if (bad_speed) begin
						status = drm_pkg::STATUS_INVALID;
					end else begin
						mcmd[item_s1.msel].set  = 1'b1;
						mcmd[item_s1.msel].duty = item_s1.speed[6:0];
						mcmd[item_s1.msel].dir  = item_s1.dir;
					end
				end
				drm_pkg::REQ_STOP: begin
					mcmd[item_s1.msel].stop = 1'b1;
				end
				drm_pkg::REQ_STOP_ALL: begin
					mcmd[0].stop = 1'b1;
					mcmd[1].stop = 1'b1;
				end
				drm_pkg::REQ_FORWARD, drm_pkg::REQ_BACKWARD: begin
					if (bad_speed) begin
						status = drm_pkg::STATUS_INVALID;
					end else begin
						for (int m = 0; m < 2; m++) begin
							mcmd[m].set  = 1'b1;
							mcmd[m].duty = item_s1.speed[6:0];
							mcmd[m].dir  = (item_s1.req == drm_pkg::REQ_BACKWARD);
						end
					end
				end
				drm_pkg::REQ_TURN_LEFT, drm_pkg::REQ_TURN_RIGHT: begin
					if (bad_speed || (item_s1.radius > 8'd100)) begin
						status = drm_pkg::STATUS_INVALID;
					end else begin
						mcmd[~inner].set  = 1'b1;
						mcmd[~inner].duty = item_s1.speed[6:0];
						mcmd[~inner].dir  = 1'b0;
						mcmd[inner].set   = 1'b1;
						mcmd[inner].duty  = inner_duty;
						mcmd[inner].dir   = item_s1.neg;
					end
				end
				default: ;
			endcase
		end
	end

	for (genvar m = 0; m < 2; m++) begin : g_motor
		drm_motor u_motor (
			.clk    (clk),
			.arst_n (arst_n),
			.upd    (fire),
			.step   (step),
			.cmd    (mcmd[m]),
			.view   (view[m])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.valid <= 1'b0;
		end else if (advance) begin
			rsp.valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp.left_in1_gpio  <= view[0].dir;
			rsp.left_in2_gpio  <= ~view[0].dir;
			rsp.left_pwm_word  <= pwm_lut[view[0].duty];
			rsp.right_in1_gpio <= view[1].dir;
			rsp.right_in2_gpio <= ~view[1].dir;
			rsp.right_pwm_word <= pwm_lut[view[1].duty];
			rsp.left_duty      <= view[0].duty;
			rsp.right_duty     <= view[1].duty;
			rsp.status         <= status;
			rsp.ramping        <= !(view[0].settled && view[1].settled);
		end
	end

endmodule

>>> rtl/drm_in_stage.sv
// ----------------------------------------------------------------------------
// drm_in_stage
// Input register; forms the turn product |speed * (2*radius - 100)|.
// ----------------------------------------------------------------------------
module drm_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	drm_cmd_if.sink           cmd,
	input  logic              advance,
	output logic              valid_s1,
	output drm_pkg::drm_s1_t  item_s1
);

	logic       take;
	logic [8:0] twice_r;
	logic [8:0] k;
	logic [16:0] prod;

	assign cmd.ready = !valid_s1 || advance;
	assign take      = cmd.valid && cmd.ready;
	assign twice_r   = {cmd.radius_value, 1'b0};
	assign k         = (cmd.radius_value >= 8'd50) ? (twice_r - 9'd100) : (9'd100 - twice_r);
	assign prod      = 17'(cmd.speed_value) * 17'(k);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.req    <= drm_pkg::req_e'(cmd.req_type);
			item_s1.msel   <= cmd.motor_select;
			item_s1.speed  <= cmd.speed_value;
			item_s1.dir    <= cmd.direction;
			item_s1.radius <= cmd.radius_value;
			item_s1.mag    <= prod[drm_pkg::MAG_W-1:0];
			item_s1.neg    <= (cmd.radius_value < 8'd50) && (cmd.speed_value != 8'd0);
		end
	end

endmodule

>>> rtl/drm_motor.sv
// ----------------------------------------------------------------------------
// drm_motor
// One motor channel: applied and target duty/direction, tick ramp update.
// ----------------------------------------------------------------------------
module drm_motor (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    upd,
	input  logic [6:0]              step,
	input  drm_pkg::drm_motor_cmd_t cmd,
	output drm_pkg::drm_motor_view_t view
);

	logic [6:0] app_duty_q;
	logic       app_dir_q;
	logic [6:0] tgt_duty_q;
	logic       tgt_dir_q;
	logic [6:0] nd;
	logic       ndir;
	logic [6:0] ntd;
	logic       ntdir;
	logic [6:0] down;

	function automatic logic [6:0] move_toward(logic [6:0] cur, logic [6:0] tgt,
		logic [6:0] s);
		logic [7:0] up;
		up = 8'(cur) + 8'(s);
		if (cur < tgt) begin
			return ((tgt - cur) > s) ? up[6:0] : tgt;
		end else if (cur > tgt) begin
			return ((cur - tgt) > s) ? (cur - s) : tgt;
		end
		return cur;
	endfunction

	assign down = (app_duty_q > step) ? (app_duty_q - step) : 7'd0;

	always_comb begin
		nd    = app_duty_q;
		ndir  = app_dir_q;
		ntd   = tgt_duty_q;
		ntdir = tgt_dir_q;
		if (cmd.tick) begin
			if ((app_dir_q != tgt_dir_q) && (app_duty_q != 7'd0)) begin
				nd = down;
				if (down == 7'd0) begin
					ndir = tgt_dir_q;
				end
			end else begin
				ndir = tgt_dir_q;
				nd   = move_toward(app_duty_q, tgt_duty_q, step);
			end
		end else if (cmd.set) begin
			ntd   = cmd.duty;
			ntdir = cmd.dir;
		end else if (cmd.stop) begin
			ntd   = 7'd0;
			ntdir = app_dir_q;
		end
	end

	assign view.duty    = nd;
	assign view.dir     = ndir;
	assign view.settled = (nd == ntd) && (ndir == ntdir);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			app_duty_q <= 7'd0;
			app_dir_q  <= 1'b0;
			tgt_duty_q <= 7'd0;
			tgt_dir_q  <= 1'b0;
		end else if (upd) begin
			app_duty_q <= nd;
			app_dir_q  <= ndir;
			tgt_duty_q <= ntd;
			tgt_dir_q  <= ntdir;
		end
	end

endmodule

>>> rtl/drm_checker.sv
// ----------------------------------------------------------------------------
// drm_checker
// Port-level checks on the result channel of the motor controller.
// ----------------------------------------------------------------------------
module drm_checker #(
	parameter int unsigned PWM_RANGE = drm_pkg::PWM_RANGE_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  status,
	input logic        left_in1,
	input logic        left_in2,
	input logic        right_in1,
	input logic        right_in2,
	input logic [6:0]  left_duty,
	input logic [6:0]  right_duty,
	input logic [19:0] left_pwm,
	input logic [19:0] right_pwm
);

	localparam logic [19:0] PwmFull = 20'(PWM_RANGE);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) &&
		$stable(left_duty) && $stable(right_duty))
		else $error("result dropped or changed while stalled");

	a_pins: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (left_in1 != left_in2) && (right_in1 != right_in2))
		else $error("bridge inputs not complementary");

	a_duty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (left_duty <= 7'd100) && (right_duty <= 7'd100))
		else $error("duty above full scale");

	a_pwm: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((left_duty != 7'd0) || (left_pwm == PwmFull)) &&
		((right_duty != 7'd0) || (right_pwm == PwmFull)) &&
		((left_duty != 7'd100) || (left_pwm == 20'd0)) &&
		((right_duty != 7'd100) || (right_pwm == 20'd0)))
		else $error("pwm word does not match duty end point");

endmodule

bind dual_motor_ramp_controller drm_checker #(.PWM_RANGE(PWM_RANGE)) u_drm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.status     (rsp.status),
	.left_in1   (rsp.left_in1_gpio),
	.left_in2   (rsp.left_in2_gpio),
	.right_in1  (rsp.right_in1_gpio),
	.right_in2  (rsp.right_in2_gpio),
	.left_duty  (rsp.left_duty),
	.right_duty (rsp.right_duty),
	.left_pwm   (rsp.left_pwm_word),
	.right_pwm  (rsp.right_pwm_word)
);
